### design/srit_pkg.sv
// ----------------------------------------------------------------------------
// srit_pkg: shared types and constants of the sorted reminder table
// Field widths, status codes and the layout of one stored table entry.
// ----------------------------------------------------------------------------
package srit_pkg;

	localparam int DATE_W   = 7;
	localparam int TAG_W    = 32;
	localparam int STATUS_W = 3;
	localparam int MAX_DAY  = 31;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	localparam logic FUNC_INSERT  = 1'b0;
	localparam logic FUNC_READOUT = 1'b1;

	typedef struct packed {
		logic [DATE_W-1:0] month;
		logic [DATE_W-1:0] day;
		logic [DATE_W-1:0] hour;
		logic [DATE_W-1:0] minute;
		logic [TAG_W-1:0]  tag;
		logic              empty;
	} entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		entry_t              ent;
		logic                last;
	} result_t;

endpackage

### design/srit_req_if.sv
// ----------------------------------------------------------------------------
// srit_req_if: request channel of the sorted reminder table
// Valid/ready handshake carrying one insert or readout request.
// ----------------------------------------------------------------------------
interface srit_req_if import srit_pkg::*; ;

	logic              valid;
	logic              ready;
	logic              func;
	logic [DATE_W-1:0] month;
	logic [DATE_W-1:0] day;
	logic [DATE_W-1:0] hour;
	logic [DATE_W-1:0] minute;
	logic [TAG_W-1:0]  msg_tag;
	logic              msg_empty;

	modport source (
		output valid, func, month, day, hour, minute, msg_tag, msg_empty,
		input  ready
	);

	modport sink (
		input  valid, func, month, day, hour, minute, msg_tag, msg_empty,
		output ready
	);

endinterface

### design/srit_rsp_if.sv
// ----------------------------------------------------------------------------
// srit_rsp_if: response channel of the sorted reminder table
// Valid/ready handshake carrying one status or listed entry.
// ----------------------------------------------------------------------------
interface srit_rsp_if import srit_pkg::*; ;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATE_W-1:0]   out_month;
	logic [DATE_W-1:0]   out_day;
	logic [DATE_W-1:0]   out_hour;
	logic [DATE_W-1:0]   out_minute;
	logic [TAG_W-1:0]    out_tag;
	logic                out_empty;
	logic                last;

	modport source (
		output valid, status, out_month, out_day, out_hour, out_minute,
		       out_tag, out_empty, last,
		input  ready
	);

	modport sink (
		input  valid, status, out_month, out_day, out_hour, out_minute,
		       out_tag, out_empty, last,
		output ready
	);

endinterface

### design/srit_ram.sv
// ----------------------------------------------------------------------------
// srit_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held until the
// next read.
// ----------------------------------------------------------------------------
module srit_ram #(
	parameter int WIDTH = 61,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/sorted_reminder_insert_table_core.sv
// ----------------------------------------------------------------------------
// sorted_reminder_insert_table_core: sorted table of dated reminders
// Keeps up to CAPACITY entries in one RAM, ordered by month, day, hour and
// minute; inserts in place and lists the table on request.
// ----------------------------------------------------------------------------
// An insert walks the stored entries once from the front through the single
// entry RAM, one entry per cycle: once the insert point is found each entry
// is read and written back one place further up, and the carried entry is then
// written to the new tail slot; an insert into an empty table writes the entry
// straight to the first slot. A readout streams one listed entry per cycle as
// long as the response side keeps taking them. Full, invalid-date and
// empty-list requests go straight to the status response. One request is
// handled at a time; the response register lets the next request be taken
// while the last response of the previous one is still waiting.
// ----------------------------------------------------------------------------
module sorted_reminder_insert_table_core import srit_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	srit_req_if.sink     req,
	srit_rsp_if.source   rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = $bits(entry_t);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_TAIL = 3'd2;
	localparam logic [2:0] S_RESP = 3'd3;
	localparam logic [2:0] S_LIST = 3'd4;

	logic [2:0]          state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic                found_q, found_d;
	entry_t              carry_q, carry_d;
	entry_t              new_q;
	logic [STATUS_W-1:0] rstat_q, rstat_d;
	result_t             out_q, out_d;
	logic                out_valid_q;
	logic                out_load;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	entry_t              ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [EW-1:0]       ram_rdata;
	entry_t              rd_ent;

	entry_t              in_ent;
	logic                req_acc;
	logic                out_free;
	logic                idx_last;
	logic                date_bad;
	logic                hit;
	logic [4*DATE_W-1:0] rd_key, new_key;

	srit_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_ent = entry_t'(ram_rdata);

	assign in_ent.month  = req.month;
	assign in_ent.day    = req.day;
	assign in_ent.hour   = req.hour;
	assign in_ent.minute = req.minute;
	assign in_ent.tag    = req.msg_tag;
	assign in_ent.empty  = req.msg_empty;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign idx_last  = ((CW'(idx_q) + CW'(1)) == count_q);
	assign date_bad  = (req.month == '0) || (req.day == '0) ||
	                   (req.day > DATE_W'(MAX_DAY));

	assign rd_key  = {rd_ent.month, rd_ent.day, rd_ent.hour, rd_ent.minute};
	assign new_key = {new_q.month, new_q.day, new_q.hour, new_q.minute};
	// insert point: first entry with a later key, or same key and a message
	assign hit = found_q || (rd_key > new_key) || ((rd_key == new_key) && !rd_ent.empty);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		found_d   = found_q;
		carry_d   = carry_q;
		rstat_d   = rstat_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = carry_q;
		ram_re    = 1'b0;
		ram_raddr = idx_q + AW'(1);
		out_load  = 1'b0;
		out_d     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					idx_d   = '0;
					found_d = 1'b0;
					carry_d = in_ent;
					if (req.func == FUNC_READOUT) begin
						if (count_q == '0) begin
							rstat_d = ST_EMPTY;
							state_d = S_RESP;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = '0;
							state_d   = S_LIST;
						end
					end else if (count_q == CW'(CAPACITY)) begin
						rstat_d = ST_FULL;
						state_d = S_RESP;
					end else if (date_bad) begin
						rstat_d = ST_INVALID;
						state_d = S_RESP;
					end else if (count_q == '0) begin
						ram_we    = 1'b1;
						ram_waddr = '0;
						ram_wdata = in_ent;
						count_d   = CW'(1);
						rstat_d   = ST_INSERTED;
						state_d   = S_RESP;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = '0;
						state_d   = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// once placed, each entry moves up by one place
				if (hit) begin
					ram_we  = 1'b1;
					carry_d = rd_ent;
					found_d = 1'b1;
				end
				if (idx_last) begin
					state_d = S_TAIL;
				end else begin
					ram_re = 1'b1;
					idx_d  = idx_q + AW'(1);
				end
			end
			S_TAIL: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(count_q);
				count_d   = count_q + CW'(1);
				rstat_d   = ST_INSERTED;
				state_d   = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_d.status = rstat_q;
					out_d.last   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_LIST: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_d.status = ST_ENTRY;
					out_d.ent    = rd_ent;
					out_d.last   = idx_last;
					if (idx_last) begin
						state_d = S_IDLE;
					end else begin
						ram_re = 1'b1;
						idx_d  = idx_q + AW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		found_q <= found_d;
		carry_q <= carry_d;
		rstat_q <= rstat_d;
		if (req_acc) begin
			new_q <= in_ent;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_q.status;
	assign rsp.out_month  = out_q.ent.month;
	assign rsp.out_day    = out_q.ent.day;
	assign rsp.out_hour   = out_q.ent.hour;
	assign rsp.out_minute = out_q.ent.minute;
	assign rsp.out_tag    = out_q.ent.tag;
	assign rsp.out_empty  = out_q.ent.empty;
	assign rsp.last       = out_q.last;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("read and write of the same entry in one cycle");

	a_tail_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAIL) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the table");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_ENTRY)) |-> rsp.last)
		else $error("status response not marked last");

endmodule
